@@ design/i2c_bitbang_master_defines.svh @@
// ----------------------------------------------------------------------------
// I2C bit-bang master assertion macros
// Concurrent assertion helpers used by the top-level design file of the block.
// ----------------------------------------------------------------------------
`ifndef I2C_BITBANG_MASTER_DEFINES_SVH
`define I2C_BITBANG_MASTER_DEFINES_SVH

`ifndef SYNTHESIS
// Clocked property that is switched off while reset is asserted.
`define I2CBB_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked property that must hold during reset as well.
`define I2CBB_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I2CBB_ASSERT(label, clk, rstn, prop, msg)
`define I2CBB_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

@@ design/i2cbb_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C bit-bang master package
// Types, command codes and the sequencer program shared by the design files.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbb_pkg;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // Request codes carried by each tick.
    localparam logic [2:0] REQ_TICK  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;
    localparam logic [2:0] REQ_ACK   = 3'd5;
    localparam logic [2:0] REQ_NACK  = 3'd6;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SETTLE    = 2'd0;
    localparam logic [1:0] CFG_ACK_SETUP = 2'd1;
    localparam logic [1:0] CFG_ACK_HOLD  = 2'd2;
    localparam logic [1:0] CFG_LONG_HOLD = 2'd3;

    localparam logic [15:0] SETTLE_RESET    = 16'd24;
    localparam logic [15:0] ACK_SETUP_RESET = 16'd100;
    localparam logic [15:0] ACK_HOLD_RESET  = 16'd10;
    localparam logic [15:0] LONG_HOLD_RESET = 16'd1429;

    // Sequencer program addresses with a special meaning.
    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_START  = 5'd1;
    localparam logic [4:0] PH_STOP   = 5'd5;
    localparam logic [4:0] PH_WRITE  = 5'd9;
    localparam logic [4:0] PH_READ   = 5'd18;
    localparam logic [4:0] PH_ACK    = 5'd21;
    localparam logic [4:0] PH_NACK   = 5'd26;
    localparam logic [4:0] PH_FINISH = 5'd31;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_SCL_H      = 4'd1,
        OP_SCL_L      = 4'd2,
        OP_SDA_H      = 4'd3,
        OP_SDA_L      = 4'd4,
        OP_SDA_BIT    = 4'd5,
        OP_SCL_L_TX   = 4'd6,
        OP_W_SETUP    = 4'd7,
        OP_SAMPLE_ACK = 4'd8,
        OP_W_HOLD     = 4'd9,
        OP_SAMPLE_BIT = 4'd10,
        OP_SCL_L_RX   = 4'd11,
        OP_W_LONG     = 4'd12
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] nxt;
    } prog_step_t;

    typedef struct packed {
        logic [15:0] settle;
        logic [15:0] ack_setup;
        logic [15:0] ack_hold;
        logic [15:0] long_hold;
    } cfg_t;

    typedef struct packed {
        logic [4:0]  phase;
        logic [3:0]  bit_index;
        logic [7:0]  shift;
        logic [15:0] wait_cnt;
        logic        scl;
        logic        sda;
        logic        ack;
        logic [7:0]  rx;
    } seq_state_t;

    // Program ROM: one pin action per address and the address that follows.
    function automatic prog_step_t prog_rom(input logic [4:0] ph);
        prog_step_t s;
        case (ph)
            5'd1:    s = '{OP_SDA_H,      5'd2};
            5'd2:    s = '{OP_SCL_H,      5'd3};
            5'd3:    s = '{OP_SDA_L,      5'd4};
            5'd4:    s = '{OP_SCL_L,      PH_FINISH};
            5'd5:    s = '{OP_SCL_L,      5'd6};
            5'd6:    s = '{OP_SDA_L,      5'd7};
            5'd7:    s = '{OP_SCL_H,      5'd8};
            5'd8:    s = '{OP_SDA_H,      PH_FINISH};
            5'd9:    s = '{OP_SDA_BIT,    5'd10};
            5'd10:   s = '{OP_SCL_H,      5'd11};
            5'd11:   s = '{OP_SCL_L_TX,   5'd12};
            5'd12:   s = '{OP_SDA_H,      5'd13};
            5'd13:   s = '{OP_W_SETUP,    5'd14};
            5'd14:   s = '{OP_SCL_H,      5'd15};
            5'd15:   s = '{OP_SAMPLE_ACK, 5'd16};
            5'd16:   s = '{OP_W_HOLD,     5'd17};
            5'd17:   s = '{OP_SCL_L,      PH_FINISH};
            5'd18:   s = '{OP_SCL_H,      5'd19};
            5'd19:   s = '{OP_SAMPLE_BIT, 5'd20};
            5'd20:   s = '{OP_SCL_L_RX,   PH_FINISH};
            5'd21:   s = '{OP_SDA_L,      5'd22};
            5'd22:   s = '{OP_SCL_H,      5'd23};
            5'd23:   s = '{OP_W_LONG,     5'd24};
            5'd24:   s = '{OP_SCL_L,      5'd25};
            5'd25:   s = '{OP_SDA_H,      PH_FINISH};
            5'd26:   s = '{OP_SCL_L,      5'd27};
            5'd27:   s = '{OP_W_LONG,     5'd28};
            5'd28:   s = '{OP_SDA_H,      5'd29};
            5'd29:   s = '{OP_W_LONG,     5'd30};
            5'd30:   s = '{OP_SCL_H,      PH_FINISH};
            default: s = '{OP_NONE,       PH_FINISH};
        endcase
        return s;
    endfunction

    // First program address of each request; idle for tick-only and unused codes.
    function automatic logic [4:0] entry_of(input logic [2:0] req);
        logic [4:0] e;
        case (req)
            REQ_START: e = PH_START;
            REQ_STOP:  e = PH_STOP;
            REQ_WRITE: e = PH_WRITE;
            REQ_READ:  e = PH_READ;
            REQ_ACK:   e = PH_ACK;
            REQ_NACK:  e = PH_NACK;
            default:   e = PH_IDLE;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

@@ design/i2cbb_step.sv @@
// ----------------------------------------------------------------------------
// I2C bit-bang sequencer step
// Runs the tick bookkeeping and at most one pin action of the program.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbb_step (
    input  var i2cbb_pkg::seq_state_t cur,
    input  var i2cbb_pkg::cfg_t       cfg,
    input  var logic                  first,
    input  var logic [2:0]            req,
    input  var logic [7:0]            wbyte,
    input  var logic                  sda_in,
    output i2cbb_pkg::seq_state_t     nxt_state,
    output logic                      done,
    output logic                      cont
);
    import i2cbb_pkg::*;

    seq_state_t n;
    prog_step_t stp;
    logic [15:0] w;
    logic [4:0]  nxt;
    logic [4:0]  ent;
    logic [3:0]  bi;

    always_comb begin
        n    = cur;
        done = 1'b0;
        cont = 1'b0;
        ent  = entry_of(req);
        stp  = prog_rom(cur.phase);
        w    = cfg.settle;
        nxt  = PH_IDLE;
        bi   = 4'd0;

        // Start of a tick: take a command when idle, otherwise count down.
        if (first) begin
            if (n.phase == PH_IDLE) begin
                if (ent != PH_IDLE) begin
                    n.phase     = ent;
                    n.bit_index = 4'd0;
                    n.wait_cnt  = 16'd0;
                    n.shift     = (req == REQ_WRITE) ? wbyte : 8'd0;
                end
            end else if (n.wait_cnt != 16'd0) begin
                n.wait_cnt = n.wait_cnt - 16'd1;
            end
        end

        if (n.phase != PH_IDLE && n.wait_cnt == 16'd0) begin
            if (n.phase == PH_FINISH) begin
                n.phase = PH_IDLE;
                done    = 1'b1;
            end else begin
                stp = prog_rom(n.phase);
                nxt = stp.nxt;
                case (stp.op)
                    OP_SCL_H:   n.scl = 1'b1;
                    OP_SCL_L:   n.scl = 1'b0;
                    OP_SDA_H:   n.sda = 1'b1;
                    OP_SDA_L:   n.sda = 1'b0;
                    OP_SDA_BIT: n.sda = n.shift[7];
                    OP_SCL_L_TX: begin
                        n.scl       = 1'b0;
                        n.shift     = {n.shift[6:0], 1'b0};
                        bi          = n.bit_index + 4'd1;
                        n.bit_index = bi;
                        if (bi < BITS_PER_BYTE) begin
                            nxt = PH_WRITE;
                        end
                    end
                    OP_W_SETUP: w = cfg.ack_setup;
                    OP_SAMPLE_ACK: begin
                        n.ack = sda_in;
                        w     = 16'd0;
                    end
                    OP_W_HOLD: w = cfg.ack_hold;
                    OP_SAMPLE_BIT: begin
                        n.sda   = 1'b1;
                        n.shift = {n.shift[6:0], sda_in};
                        w       = 16'd0;
                    end
                    OP_SCL_L_RX: begin
                        n.scl       = 1'b0;
                        bi          = n.bit_index + 4'd1;
                        n.bit_index = bi;
                        if (bi < BITS_PER_BYTE) begin
                            nxt = PH_READ;
                        end else begin
                            n.rx = n.shift;
                        end
                    end
                    OP_W_LONG: w = cfg.long_hold;
                    default:   w = 16'd0;
                endcase
                n.phase    = nxt;
                n.wait_cnt = w;
                // A zero wait into the finish address closes the command at once.
                if (nxt == PH_FINISH && w == 16'd0) begin
                    n.phase = PH_IDLE;
                    done    = 1'b1;
                end else begin
                    cont = (w == 16'd0);
                end
            end
        end
        nxt_state = n;
    end

endmodule

`default_nettype wire

@@ design/i2c_bitbang_master.sv @@
// Timing: a tick is held in the input register while the step unit runs on it, and
// its result is registered once no zero-wait action is left and the slot is free.
// Rate: one tick per cycle while the result slot is free and no action is chained;
// a pin action that follows another with a zero wait inside the same tick holds
// the input, since the step unit runs one program action per cycle.
// Reset: synchronous, active low; bus released, sequencer idle, config at defaults.
`default_nettype none

`include "i2c_bitbang_master_defines.svh"

// ----------------------------------------------------------------------------
// I2C bit-bang master
// Tick-driven bit-level I2C master sequencer with start, stop, byte write,
// byte read, ACK and NACK commands.
// ----------------------------------------------------------------------------
module i2c_bitbang_master (
    input  var logic        aclk,
    input  var logic        aresetn,
    // Configuration write port.
    input  var logic        cfg_we,
    input  var logic [1:0]  cfg_index,
    input  var logic [15:0] cfg_wdata,
    // Tick input channel.
    input  var logic        s_valid,
    output logic            s_ready,
    input  var logic [2:0]  s_req_type,
    input  var logic [7:0]  s_write_byte,
    input  var logic        s_sda_level,
    // Result channel.
    output logic            m_valid,
    input  var logic        m_ready,
    output logic            m_scl_high,
    output logic            m_sda_released,
    output logic            m_busy_res,
    output logic            m_done_res,
    output logic [7:0]      m_rx_byte,
    output logic            m_ack_missing
);
    import i2cbb_pkg::*;

    // Configuration registers.
    cfg_t cfg_reg;

    // Input register: holds the tick transaction until its step completes.
    logic       in_valid_reg;
    logic [2:0] in_req_reg;
    logic [7:0] in_wbyte_reg;
    logic       in_sda_reg;

    // Set while a tick is chaining further zero-wait actions.
    logic chain_reg;

    // Sequencer state.
    seq_state_t st_reg;
    seq_state_t st_next;

    // Result register.
    logic       m_valid_reg;
    logic       scl_reg;
    logic       sda_reg;
    logic       busy_reg;
    logic       done_reg;
    logic [7:0] rx_reg;
    logic       ack_reg;

    logic step_done;
    logic step_cont;
    logic out_free;
    logic item_done;
    logic state_adv;
    logic in_take;

    // The step unit does the tick bookkeeping on the first cycle of a tick
    // and then runs one program action per cycle.
    i2cbb_step u_step (
        .cur       (st_reg),
        .cfg       (cfg_reg),
        .first     (!chain_reg),
        .req       (in_req_reg),
        .wbyte     (in_wbyte_reg),
        .sda_in    (in_sda_reg),
        .nxt_state (st_next),
        .done      (step_done),
        .cont      (step_cont)
    );

    // The result slot is free when empty or being emptied this cycle.
    assign out_free  = !m_valid_reg || m_ready;
    // A tick finishes when no zero-wait action is left and its result fits.
    assign item_done = in_valid_reg && !step_cont && out_free;
    // Chained actions commit state without producing a result.
    assign state_adv = in_valid_reg && (step_cont || out_free);
    assign s_ready   = !in_valid_reg || item_done;
    assign in_take   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle    <= SETTLE_RESET;
            cfg_reg.ack_setup <= ACK_SETUP_RESET;
            cfg_reg.ack_hold  <= ACK_HOLD_RESET;
            cfg_reg.long_hold <= LONG_HOLD_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SETTLE:    cfg_reg.settle    <= cfg_wdata;
                CFG_ACK_SETUP: cfg_reg.ack_setup <= cfg_wdata;
                CFG_ACK_HOLD:  cfg_reg.ack_hold  <= cfg_wdata;
                CFG_LONG_HOLD: cfg_reg.long_hold <= cfg_wdata;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            chain_reg    <= 1'b0;
        end else begin
            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (item_done) begin
                in_valid_reg <= 1'b0;
            end
            if (item_done) begin
                chain_reg <= 1'b0;
            end else if (in_valid_reg && step_cont) begin
                chain_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_req_reg   <= s_req_type;
            in_wbyte_reg <= s_write_byte;
            in_sda_reg   <= s_sda_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg.phase     <= PH_IDLE;
            st_reg.bit_index <= 4'd0;
            st_reg.shift     <= 8'd0;
            st_reg.wait_cnt  <= 16'd0;
            st_reg.scl       <= 1'b1;
            st_reg.sda       <= 1'b1;
            st_reg.ack       <= 1'b0;
            st_reg.rx        <= 8'd0;
        end else if (state_adv) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (item_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Result payload is the state after the tick.
    always_ff @(posedge aclk) begin
        if (item_done) begin
            scl_reg  <= st_next.scl;
            sda_reg  <= st_next.sda;
            busy_reg <= (st_next.phase != PH_IDLE);
            done_reg <= step_done;
            rx_reg   <= st_next.rx;
            ack_reg  <= st_next.ack;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_scl_high     = scl_reg;
    assign m_sda_released = sda_reg;
    assign m_busy_res     = busy_reg;
    assign m_done_res     = done_reg;
    assign m_rx_byte      = rx_reg;
    assign m_ack_missing  = ack_reg;

    // A completed command leaves the sequencer idle.
    `I2CBB_ASSERT(a_done_not_busy, aclk, aresetn, (m_valid && m_done_res) |-> !m_busy_res, "done reported while still busy")
    // The sequencer only rests at idle with no wait pending.
    `I2CBB_ASSERT(a_idle_no_wait, aclk, aresetn, (st_reg.phase == PH_IDLE) |-> (st_reg.wait_cnt == 16'd0), "idle with wait pending")
    // Bit counter never runs past one byte.
    `I2CBB_ASSERT(a_bit_range, aclk, aresetn, st_reg.bit_index <= BITS_PER_BYTE, "bit index beyond byte")
    // A chained tick keeps its transaction in the input register.
    `I2CBB_ASSERT(a_chain_holds, aclk, aresetn, chain_reg |-> in_valid_reg, "chain without held tick")
    // Reset empties the result slot and ends any chain.
    `I2CBB_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> (!m_valid && !chain_reg), "reset left work pending")
    // A tick only finishes into a free result slot.
    `I2CBB_ASSERT(a_no_overrun, aclk, aresetn, (m_valid && !m_ready) |=> $stable(m_rx_byte) && $stable(m_done_res), "result overwritten while stalled")

endmodule

`default_nettype wire

@@ bench/i2c_bitbang_master_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang master result checker
// Watches the tick and result channels and the configuration port. It keeps
// its own model of the bus sequencer and compares every result transaction
// with the oldest predicted bus view.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [7:0]  s_write_byte,
    input  logic        s_sda_level,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_scl_high,
    input  logic        m_sda_released,
    input  logic        m_busy_res,
    input  logic        m_done_res,
    input  logic [7:0]  m_rx_byte,
    input  logic        m_ack_missing,
    output int          fail_count,
    output int          pending,
    output logic        seq_idle,
    output int          ticks_seen,
    output int          cmds_started,
    output int          cmds_done
);
    import i2cbb_pkg::*;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
    } bus_view_t;

    bus_view_t   bus_view_q[$];

    logic [15:0] settle_r, setup_r, hold_r, long_r;
    logic [4:0]  phase;
    logic [3:0]  bit_cnt;
    logic [7:0]  shreg;
    logic [15:0] wcnt;
    logic        scl_q, sda_q, ack_q;
    logic [7:0]  rx_q;

    // Pin action and successor of each sequencer address.
    function automatic void seq_lookup(input logic [4:0] ph, output op_t op,
                                       output logic [4:0] nxt);
        nxt = ph + 5'd1;
        case (ph)
            PH_START:          op = OP_SDA_H;
            PH_START + 5'd1:   op = OP_SCL_H;
            PH_START + 5'd2:   op = OP_SDA_L;
            PH_START + 5'd3: begin op = OP_SCL_L; nxt = PH_FINISH; end
            PH_STOP:           op = OP_SCL_L;
            PH_STOP + 5'd1:    op = OP_SDA_L;
            PH_STOP + 5'd2:    op = OP_SCL_H;
            PH_STOP + 5'd3: begin op = OP_SDA_H; nxt = PH_FINISH; end
            PH_WRITE:          op = OP_SDA_BIT;
            PH_WRITE + 5'd1:   op = OP_SCL_H;
            PH_WRITE + 5'd2:   op = OP_SCL_L_TX;
            PH_WRITE + 5'd3:   op = OP_SDA_H;
            PH_WRITE + 5'd4:   op = OP_W_SETUP;
            PH_WRITE + 5'd5:   op = OP_SCL_H;
            PH_WRITE + 5'd6:   op = OP_SAMPLE_ACK;
            PH_WRITE + 5'd7:   op = OP_W_HOLD;
            PH_WRITE + 5'd8: begin op = OP_SCL_L; nxt = PH_FINISH; end
            PH_READ:           op = OP_SCL_H;
            PH_READ + 5'd1:    op = OP_SAMPLE_BIT;
            PH_READ + 5'd2: begin op = OP_SCL_L_RX; nxt = PH_FINISH; end
            PH_ACK:            op = OP_SDA_L;
            PH_ACK + 5'd1:     op = OP_SCL_H;
            PH_ACK + 5'd2:     op = OP_W_LONG;
            PH_ACK + 5'd3:     op = OP_SCL_L;
            PH_ACK + 5'd4: begin op = OP_SDA_H; nxt = PH_FINISH; end
            PH_NACK:           op = OP_SCL_L;
            PH_NACK + 5'd1:    op = OP_W_LONG;
            PH_NACK + 5'd2:    op = OP_SDA_H;
            PH_NACK + 5'd3:    op = OP_W_LONG;
            PH_NACK + 5'd4: begin op = OP_SCL_H; nxt = PH_FINISH; end
            default: begin op = OP_NONE; nxt = PH_FINISH; end
        endcase
    endfunction

    // Executes the action at the current address and returns the wait after it.
    task automatic pin_action(input logic sda_in, output logic [15:0] w);
        op_t        op;
        logic [4:0] nxt;
        seq_lookup(phase, op, nxt);
        w = settle_r;
        case (op)
            OP_SCL_H:   scl_q = 1'b1;
            OP_SCL_L:   scl_q = 1'b0;
            OP_SDA_H:   sda_q = 1'b1;
            OP_SDA_L:   sda_q = 1'b0;
            OP_SDA_BIT: sda_q = shreg[7];
            OP_SCL_L_TX: begin
                scl_q   = 1'b0;
                shreg   = {shreg[6:0], 1'b0};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < BITS_PER_BYTE) nxt = PH_WRITE;
            end
            OP_W_SETUP: w = setup_r;
            OP_SAMPLE_ACK: begin
                ack_q = sda_in;
                w     = '0;
            end
            OP_W_HOLD: w = hold_r;
            OP_SAMPLE_BIT: begin
                sda_q = 1'b1;
                shreg = {shreg[6:0], sda_in};
                w     = '0;
            end
            OP_SCL_L_RX: begin
                scl_q   = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt < BITS_PER_BYTE) nxt = PH_READ;
                else rx_q = shreg;
            end
            OP_W_LONG: w = long_r;
            default:   w = '0;
        endcase
        phase = nxt;
    endtask

    // One tick of the sequencer: take a command if idle, count down, then run
    // every action whose wait has run out.
    task automatic bus_tick(input logic [2:0] req, input logic [7:0] wb,
                            input logic sda_in, output bus_view_t view);
        logic       done;
        logic [4:0] entry;
        done = 1'b0;
        if (phase == PH_IDLE) begin
            case (req)
                REQ_START: entry = PH_START;
                REQ_STOP:  entry = PH_STOP;
                REQ_WRITE: entry = PH_WRITE;
                REQ_READ:  entry = PH_READ;
                REQ_ACK:   entry = PH_ACK;
                REQ_NACK:  entry = PH_NACK;
                default:   entry = PH_IDLE;
            endcase
            if (entry != PH_IDLE) begin
                phase   = entry;
                bit_cnt = '0;
                wcnt    = '0;
                shreg   = (req == REQ_WRITE) ? wb : 8'h00;
                cmds_started++;
            end
        end else if (wcnt != 16'd0) begin
            wcnt = wcnt - 16'd1;
        end
        while (phase != PH_IDLE && wcnt == 16'd0) begin
            if (phase == PH_FINISH) begin
                phase = PH_IDLE;
                done  = 1'b1;
            end else begin
                pin_action(sda_in, wcnt);
            end
        end
        view = '{scl_q, sda_q, phase != PH_IDLE, done, rx_q, ack_q};
    endtask

    task automatic report(input string what, input bus_view_t want, input bus_view_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0s: expected scl=%b sda=%b busy=%b done=%b rx=%h ack=%b, got scl=%b sda=%b busy=%b done=%b rx=%h ack=%b",
                     what, want.scl, want.sda, want.busy, want.done, want.rx, want.ack,
                     got.scl, got.sda, got.busy, got.done, got.rx, got.ack);
    endtask

    initial begin
        fail_count   = 0;
        pending      = 0;
        seq_idle     = 1'b1;
        ticks_seen   = 0;
        cmds_started = 0;
        cmds_done    = 0;
    end

    always @(posedge aclk) begin
        bus_view_t got_v, want_v, pred_v;
        if (!aresetn) begin
            settle_r = SETTLE_RESET;
            setup_r  = ACK_SETUP_RESET;
            hold_r   = ACK_HOLD_RESET;
            long_r   = LONG_HOLD_RESET;
            phase    = PH_IDLE;
            bit_cnt  = '0;
            shreg    = '0;
            wcnt     = '0;
            scl_q    = 1'b1;
            sda_q    = 1'b1;
            ack_q    = 1'b0;
            rx_q     = '0;
            bus_view_q.delete();
        end else begin
            // Compare before predicting, so a result can never meet an
            // expectation created on the same edge.
            if (m_valid && m_ready) begin
                got_v = '{m_scl_high, m_sda_released, m_busy_res, m_done_res,
                          m_rx_byte, m_ack_missing};
                if (bus_view_q.size() == 0) begin
                    report("result with no tick outstanding", '0, got_v);
                end else begin
                    want_v = bus_view_q.pop_front();
                    if (got_v !== want_v) report("result mismatch", want_v, got_v);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SETTLE:    settle_r = cfg_wdata;
                    CFG_ACK_SETUP: setup_r  = cfg_wdata;
                    CFG_ACK_HOLD:  hold_r   = cfg_wdata;
                    CFG_LONG_HOLD: long_r   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                bus_tick(s_req_type, s_write_byte, s_sda_level, pred_v);
                bus_view_q.push_back(pred_v);
                ticks_seen++;
                if (pred_v.done) cmds_done++;
            end
        end
        pending  = bus_view_q.size();
        seq_idle = (phase == PH_IDLE);
    end

endmodule

@@ bench/i2c_bitbang_master_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit-bang master testbench
// Drives tick transactions into the sequencer under a series of timing
// settings, from all-zero waits up to long acknowledge and hold times, while a
// checker predicts every result transaction and compares it with the block's
// output.
// ----------------------------------------------------------------------------
module i2c_bitbang_master_tb;
    import i2cbb_pkg::*;

    // Code 7 is not a command; the block must treat it as a plain tick.
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    // A full run is about 1400 ticks. Even if every tick chained its longest
    // action list and both sides stalled, it stays well inside the limit.
    localparam int unsigned CYCLE_LIMIT = 200000;

    localparam int TRAFFIC_ITEMS = 230;

    typedef struct packed {
        logic [2:0] req;
        logic [7:0] data;
    } bus_cmd_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [1:0]  cfg_index    = CFG_SETTLE;
    logic [15:0] cfg_wdata    = '0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [2:0]  s_req_type   = REQ_TICK;
    logic [7:0]  s_write_byte = '0;
    logic        s_sda_level  = 1'b1;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic        m_scl_high;
    logic        m_sda_released;
    logic        m_busy_res;
    logic        m_done_res;
    logic [7:0]  m_rx_byte;
    logic        m_ack_missing;

    int          fail_count;
    int          pending;
    logic        seq_idle;
    int          ticks_seen;
    int          cmds_started;
    int          cmds_done;

    // When set, neither side inserts idle cycles.
    logic        quiet = 1'b0;
    int unsigned cycle_count = 0;

    i2c_bitbang_master uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_write_byte   (s_write_byte),
        .s_sda_level    (s_sda_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_high     (m_scl_high),
        .m_sda_released (m_sda_released),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_rx_byte      (m_rx_byte),
        .m_ack_missing  (m_ack_missing)
    );

    i2c_bitbang_master_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_write_byte   (s_write_byte),
        .s_sda_level    (s_sda_level),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_high     (m_scl_high),
        .m_sda_released (m_sda_released),
        .m_busy_res     (m_busy_res),
        .m_done_res     (m_done_res),
        .m_rx_byte      (m_rx_byte),
        .m_ack_missing  (m_ack_missing),
        .fail_count     (fail_count),
        .pending        (pending),
        .seq_idle       (seq_idle),
        .ticks_seen     (ticks_seen),
        .cmds_started   (cmds_started),
        .cmds_done      (cmds_done)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a result that never arrives ends here.
    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
        $display("i2c_bitbang_master: mismatch");
        $finish;
    end

    // The result side stalls at random, about 11 percent of the time, except in
    // quiet stretches. It changes only at the falling edge.
    always @(negedge aclk) begin
        m_ready = quiet || ($urandom_range(99) >= 11);
    end

    // Offers one tick transaction and returns at the falling edge after it was
    // taken. It is entered at a falling edge; valid is left high, so the next
    // call either replaces the payload or opens a gap.
    task automatic send_tick(input logic [2:0] req, input logic [7:0] data, input logic sda);
        if (!quiet && $urandom_range(99) < 6) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_req_type   = req;
        s_write_byte = data;
        s_sda_level  = sda;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Feeds plain ticks until the predicted sequencer is back to idle.
    task automatic settle_out();
        while (!seq_idle) send_tick(REQ_TICK, 8'($urandom), 1'($urandom));
    endtask

    // Stops the tick stream and waits until every predicted result has been
    // seen, plus a margin for the result register.
    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    // Writes all four timing registers. Only called with the block idle.
    task automatic set_timing(input logic [15:0] settle, input logic [15:0] setup,
                              input logic [15:0] hold, input logic [15:0] hold_long);
        cfg_we    = 1'b1;
        cfg_index = CFG_SETTLE;
        cfg_wdata = settle;
        @(negedge aclk);
        cfg_index = CFG_ACK_SETUP;
        cfg_wdata = setup;
        @(negedge aclk);
        cfg_index = CFG_ACK_HOLD;
        cfg_wdata = hold;
        @(negedge aclk);
        cfg_index = CFG_LONG_HOLD;
        cfg_wdata = hold_long;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // Random bus traffic. Whenever the sequencer is idle it mostly takes the
    // next command of a planned I2C transaction (start, address, data bytes or
    // reads with ACK/NACK, stop). Ticks while busy are mostly plain, with some
    // commands thrown in that the block has to ignore.
    task automatic run_traffic(input int n_items);
        bus_cmd_t   plan[$];
        bus_cmd_t   c;
        logic [2:0] req;
        logic [7:0] data;
        int         n_bytes;
        logic       reading;
        for (int i = 0; i < n_items; i++) begin
            data = 8'($urandom);
            req  = REQ_TICK;
            if (seq_idle) begin
                if (plan.size() == 0) begin
                    if ($urandom_range(99) < 80) begin
                        reading = 1'($urandom);
                        n_bytes = $urandom_range(1, 3);
                        plan.push_back('{REQ_START, 8'($urandom)});
                        plan.push_back('{REQ_WRITE, {7'($urandom), reading}});
                        for (int b = 0; b < n_bytes; b++) begin
                            if (reading) begin
                                plan.push_back('{REQ_READ, 8'($urandom)});
                                plan.push_back('{(b == n_bytes - 1) ? REQ_NACK : REQ_ACK,
                                                 8'($urandom)});
                            end else begin
                                plan.push_back('{REQ_WRITE, 8'($urandom)});
                            end
                        end
                        plan.push_back('{REQ_STOP, 8'($urandom)});
                    end else begin
                        plan.push_back('{3'($urandom_range(REQ_START, REQ_NACK)), 8'($urandom)});
                    end
                end
                if ($urandom_range(99) < 10) begin
                    req = $urandom_range(1) ? REQ_TICK : REQ_UNUSED;
                end else begin
                    c    = plan.pop_front();
                    req  = c.req;
                    data = c.data;
                end
            end else if ($urandom_range(99) < 8) begin
                req = 3'($urandom_range(7));
            end
            send_tick(req, data, 1'($urandom));
        end
        settle_out();
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Reset timing: one stop sequence with the power-on register values.
        send_tick(REQ_STOP, 8'h00, 1'b1);
        settle_out();
        drain();

        // All waits zero: every command starts and completes in its own tick,
        // and a whole byte is shifted within one tick.
        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        send_tick(REQ_START, 8'h00, 1'b1);
        send_tick(REQ_WRITE, 8'hFF, 1'b0);
        send_tick(REQ_WRITE, 8'h00, 1'b1);
        send_tick(REQ_READ, 8'h00, 1'b1);
        send_tick(REQ_READ, 8'hA5, 1'b0);
        send_tick(REQ_ACK, 8'h5A, 1'b1);
        send_tick(REQ_NACK, 8'h3C, 1'b0);
        send_tick(REQ_STOP, 8'hC3, 1'b1);
        send_tick(REQ_UNUSED, 8'hFF, 1'b1);
        send_tick(REQ_TICK, 8'h00, 1'b0);
        settle_out();
        drain();

        // Shortest settle time: writes offered on every tick of a start are
        // ignored while it runs and on its completion tick, then one is taken.
        // A read follows so the byte register is seen to hold until the end.
        set_timing(16'd1, 16'd0, 16'd0, 16'd0);
        send_tick(REQ_START, 8'h00, 1'b0);
        repeat (6) send_tick(REQ_WRITE, 8'h96, 1'b1);
        settle_out();
        send_tick(REQ_READ, 8'h00, 1'b1);
        settle_out();
        drain();

        // Random traffic under several short timing sets, one of them without
        // any idle cycles on either side.
        set_timing(16'd1, 16'd0, 16'd0, 16'd0);
        run_traffic(TRAFFIC_ITEMS);
        set_timing(16'($urandom_range(1, 3)), 16'($urandom_range(0, 6)),
                   16'($urandom_range(0, 6)), 16'($urandom_range(0, 8)));
        run_traffic(TRAFFIC_ITEMS);
        quiet = 1'b1;
        set_timing(16'($urandom_range(1, 2)), 16'($urandom_range(0, 3)),
                   16'($urandom_range(0, 3)), 16'($urandom_range(0, 4)));
        run_traffic(TRAFFIC_ITEMS);
        quiet = 1'b0;
        set_timing(16'd2, 16'd1, 16'd3, 16'd2);
        run_traffic(TRAFFIC_ITEMS);

        // Longer acknowledge and long holds.
        set_timing(16'd1, 16'd20, 16'd15, 16'd25);
        send_tick(REQ_WRITE, 8'($urandom), 1'b1);
        settle_out();
        send_tick(REQ_ACK, 8'($urandom), 1'b0);
        settle_out();
        send_tick(REQ_NACK, 8'($urandom), 1'b1);
        settle_out();
        drain();

        // Longer settle time on a single start, run without idle cycles.
        quiet = 1'b1;
        set_timing(16'd30, 16'd0, 16'd0, 16'd0);
        send_tick(REQ_START, 8'($urandom), 1'b0);
        settle_out();
        drain();
        quiet = 1'b0;

        // Wait out any result still in flight before the verdict.
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d ticks over nine timing settings, zero waits to long holds.",
                 ticks_seen);
        $display("%0d commands started, %0d completed, %0d results in error.",
                 cmds_started, cmds_done, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("i2c_bitbang_master: match");
        end else begin
            $display("i2c_bitbang_master: mismatch");
        end
        $finish;
    end

endmodule
